// ===== src/random_permutation_by_removal_macros.svh =====
// ----------------------------------------------------------------------------
// random_permutation_by_removal_macros
// Assertion macros shared by the permutation block, sampled on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RANDOM_PERMUTATION_BY_REMOVAL_MACROS_SVH
`define RANDOM_PERMUTATION_BY_REMOVAL_MACROS_SVH

// property that must hold at every sampled edge
`define RPBR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define RPBR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rpbr_pkg.sv =====
// ----------------------------------------------------------------------------
// rpbr_pkg
// Fixed widths and sequencer codes of the random permutation block.
// ----------------------------------------------------------------------------
package rpbr_pkg;

  localparam int RND_W     = 31;
  localparam int OUT_W     = 8;
  localparam int DIV_CNT_W = $clog2(RND_W);

  localparam logic [2:0] ST_FILL  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_CAP   = 3'd4;
  localparam logic [2:0] ST_SHIFT = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

endpackage

// ===== src/random_permutation_by_removal.sv =====
// ----------------------------------------------------------------------------
// random_permutation_by_removal
// Builds a random permutation of 0..PERM_SIZE-1, one element per transaction,
// by picking a pool entry at random value mod remaining and closing the gap.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | input     | in_valid_i/in_ready_o | random_value_i
//  out     | output    | out_valid_o/out_ready_i | element_o, position_o, last_o
//
// one transaction runs the restoring modulo unit, then reads the chosen entry
// and does one pool memory read and write per shifted entry
// after reset the pool is swept to identity, and again
// after each last element, with in_ready_o low meanwhile
// a stalled output holds its register; the next input is taken meanwhile and
// waits in the final step until the output register frees
// ----------------------------------------------------------------------------
`include "random_permutation_by_removal_macros.svh"

module random_permutation_by_removal #(
  parameter int PERM_SIZE = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [rpbr_pkg::RND_W-1:0] random_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rpbr_pkg::OUT_W-1:0] element_o,
  output logic [rpbr_pkg::OUT_W-1:0] position_o,
  output logic                       last_o
);

  localparam int AW    = $clog2(PERM_SIZE);
  localparam int CNT_W = $clog2(PERM_SIZE + 1);

  logic [2:0]                        state_q, state_d;
  logic [CNT_W-1:0]                  draws_q, draws_d;
  logic [CNT_W-1:0]                  rem_cnt_q, rem_cnt_d;
  logic [rpbr_pkg::RND_W-1:0]        dvd_q, dvd_d;
  logic [CNT_W-1:0]                  rem_q, rem_d;
  logic [rpbr_pkg::DIV_CNT_W-1:0]    step_q, step_d;
  logic [CNT_W-1:0]                  rd_idx_q, rd_idx_d;
  logic                              wr_pend_q, wr_pend_d;
  logic [AW-1:0]                     wr_addr_q, wr_addr_d;
  logic [AW-1:0]                     fill_q, fill_d;
  logic [rpbr_pkg::OUT_W-1:0]        chosen_q, chosen_d;
  logic                              out_valid_q, out_valid_d;
  logic [rpbr_pkg::OUT_W-1:0]        element_q, element_d;
  logic [rpbr_pkg::OUT_W-1:0]        position_q, position_d;
  logic                              last_q, last_d;

  logic [rpbr_pkg::OUT_W-1:0]        pool_mem [PERM_SIZE];
  logic [rpbr_pkg::OUT_W-1:0]        rdata_q;

  logic                              mem_rd_en;
  logic [AW-1:0]                     mem_rd_addr;
  logic                              mem_wr_en;
  logic [AW-1:0]                     mem_wr_addr;
  logic [rpbr_pkg::OUT_W-1:0]        mem_wr_data;

  logic [CNT_W:0]                    rem_sh;
  logic [CNT_W:0]                    rem_sub;
  logic [CNT_W-1:0]                  rem_nxt;
  logic                              div_last;
  logic                              sh_issue;
  logic                              emit_fire;
  logic                              is_last;
  logic [AW+rpbr_pkg::OUT_W-1:0]     fill_ext;
  logic [CNT_W+rpbr_pkg::OUT_W-1:0]  draws_ext;

  // restoring modulo step
  assign rem_sh   = {rem_q, dvd_q[rpbr_pkg::RND_W-1]};
  assign rem_sub  = rem_sh - {1'b0, rem_cnt_q};
  assign rem_nxt  = (rem_sh >= {1'b0, rem_cnt_q}) ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
  assign div_last = (step_q == rpbr_pkg::DIV_CNT_W'(rpbr_pkg::RND_W - 1));

  assign sh_issue  = (rd_idx_q < rem_cnt_q);
  assign emit_fire = (state_q == rpbr_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);
  assign is_last   = (draws_q == CNT_W'(PERM_SIZE - 1));
  assign fill_ext  = {{rpbr_pkg::OUT_W{1'b0}}, fill_q};
  assign draws_ext = {{rpbr_pkg::OUT_W{1'b0}}, draws_q};

  assign in_ready_o  = (state_q == rpbr_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign element_o   = element_q;
  assign position_o  = position_q;
  assign last_o      = last_q;

  always_comb begin
    state_d     = state_q;
    draws_d     = draws_q;
    rem_cnt_d   = rem_cnt_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    step_d      = step_q;
    rd_idx_d    = rd_idx_q;
    wr_pend_d   = wr_pend_q;
    wr_addr_d   = wr_addr_q;
    fill_d      = fill_q;
    chosen_d    = chosen_q;
    out_valid_d = out_valid_q;
    element_d   = element_q;
    position_d  = position_q;
    last_d      = last_q;
    mem_rd_en   = 1'b0;
    mem_rd_addr = rd_idx_q[AW-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = wr_addr_q;
    mem_wr_data = rdata_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      rpbr_pkg::ST_FILL: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = fill_q;
        mem_wr_data = fill_ext[rpbr_pkg::OUT_W-1:0];
        if (fill_q == AW'(PERM_SIZE - 1)) begin
          state_d = rpbr_pkg::ST_IDLE;
        end else begin
          fill_d = fill_q + 1'b1;
        end
      end
      rpbr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          rem_cnt_d = CNT_W'(PERM_SIZE) - draws_q;
          dvd_d     = random_value_i;
          rem_d     = '0;
          step_d    = '0;
          state_d   = rpbr_pkg::ST_DIV;
        end
      end
      rpbr_pkg::ST_DIV: begin
        dvd_d  = {dvd_q[rpbr_pkg::RND_W-2:0], 1'b0};
        rem_d  = rem_nxt;
        step_d = step_q + 1'b1;
        if (div_last) begin
          state_d = rpbr_pkg::ST_RD;
        end
      end
      rpbr_pkg::ST_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = rem_q[AW-1:0];
        rd_idx_d    = rem_q + 1'b1;
        state_d     = rpbr_pkg::ST_CAP;
      end
      rpbr_pkg::ST_CAP: begin
        chosen_d  = rdata_q;
        wr_pend_d = 1'b0;
        state_d   = rpbr_pkg::ST_SHIFT;
      end
      rpbr_pkg::ST_SHIFT: begin
        // read entry k while entry k-1 of the last read is written one slot lower
        mem_wr_en = wr_pend_q;
        wr_pend_d = sh_issue;
        if (sh_issue) begin
          mem_rd_en = 1'b1;
          rd_idx_d  = rd_idx_q + 1'b1;
          wr_addr_d = rd_idx_q[AW-1:0] - 1'b1;
        end else begin
          state_d = rpbr_pkg::ST_EMIT;
        end
      end
      rpbr_pkg::ST_EMIT: begin
        if (emit_fire) begin
          out_valid_d = 1'b1;
          element_d   = chosen_q;
          position_d  = draws_ext[rpbr_pkg::OUT_W-1:0];
          last_d      = is_last;
          if (is_last) begin
            draws_d = '0;
            fill_d  = '0;
            state_d = rpbr_pkg::ST_FILL;
          end else begin
            draws_d = draws_q + 1'b1;
            state_d = rpbr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = rpbr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpbr_pkg::ST_FILL;
      draws_q     <= '0;
      fill_q      <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      draws_q     <= draws_d;
      fill_q      <= fill_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_cnt_q  <= rem_cnt_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    step_q     <= step_d;
    rd_idx_q   <= rd_idx_d;
    wr_addr_q  <= wr_addr_d;
    chosen_q   <= chosen_d;
    element_q  <= element_d;
    position_q <= position_d;
    last_q     <= last_d;
  end

  // pool memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_rd_en) begin
      rdata_q <= pool_mem[mem_rd_addr];
    end
    if (mem_wr_en) begin
      pool_mem[mem_wr_addr] <= mem_wr_data;
    end
  end

  `RPBR_ASSERT(a_draws_range, draws_q < CNT_W'(PERM_SIZE), "draw count out of range")
  `RPBR_ASSERT(a_rem_below_div,
    (state_q == rpbr_pkg::ST_DIV) |-> (rem_q < rem_cnt_q),
    "partial remainder not below divisor")
  `RPBR_ASSERT(a_shift_bound,
    (state_q == rpbr_pkg::ST_SHIFT) |-> (rd_idx_q <= rem_cnt_q),
    "shift index past remaining count")
  `RPBR_ASSERT_NEXT(a_last_refill, emit_fire && is_last,
    (state_q == rpbr_pkg::ST_FILL) && (draws_q == '0) && last_o,
    "last element without refill")

endmodule
